// ----- hw/rtl/sobel_edge_magnitude_core_macros.svh -----
`ifndef SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH
`define SOBEL_EDGE_MAGNITUDE_CORE_MACROS_SVH

// Same-cycle implication, sampled on clock, off while reset is high
`define SEM_ASSERT_IMPLIES(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock, off while reset is high
`define SEM_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/sem_pkg.sv -----
`default_nettype none

package sem_pkg;

   localparam int MAX_WIDTH_DEF = 1024;

   localparam int PIX_W    = 8;
   localparam int GRAD_W   = 11;
   localparam int CFG_W_W  = 11;
   localparam int CFG_H_W  = 12;
   localparam int CSR_IX_W = 2;
   localparam int CSR_D_W  = 12;
   localparam int ROOT_STEPS = 8;

   localparam logic [CSR_IX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_IX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

   localparam logic [CFG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd640;
   localparam logic [CFG_H_W-1:0] IMAGE_HEIGHT_RST = 12'd480;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SHIFT,
      ST_GRAD,
      ST_SQ_X,
      ST_SQ_Y,
      ST_ROOT,
      ST_LOAD
   } sem_state_type;

   typedef struct packed {
      logic accept;
      logic shift;
      logic grad;
      logic sq_x;
      logic sq_y;
      logic root;
      logic load;
   } sem_cmd_type;

   typedef struct packed {
      logic produce;
      logic root_done;
      logic out_free;
   } sem_sts_type;

endpackage

`default_nettype wire

// ----- hw/rtl/sem_ram.sv -----
`default_nettype none

module sem_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- hw/rtl/sem_ctrl.sv -----
`default_nettype none

module sem_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output      logic                req_stall,
   input  wire sem_pkg::sem_sts_type sts,
   output      sem_pkg::sem_cmd_type cmd
);

   import sem_pkg::*;

   sem_state_type state_ff;
   sem_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_SHIFT;
            end
         end
         ST_SHIFT: begin
            state_in = sts.produce ? ST_GRAD : ST_IDLE;
         end
         ST_GRAD: begin
            state_in = ST_SQ_X;
         end
         ST_SQ_X: begin
            state_in = ST_SQ_Y;
         end
         ST_SQ_Y: begin
            state_in = ST_ROOT;
         end
         ST_ROOT: begin
            if (sts.root_done) begin
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            if (sts.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            cmd.accept = req_valid;
         end
         ST_SHIFT: begin
            cmd.shift = 1'b1;
         end
         ST_GRAD: begin
            cmd.grad = 1'b1;
         end
         ST_SQ_X: begin
            cmd.sq_x = 1'b1;
         end
         ST_SQ_Y: begin
            cmd.sq_y = 1'b1;
         end
         ST_ROOT: begin
            cmd.root = 1'b1;
         end
         ST_LOAD: begin
            cmd.load = sts.out_free;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sem_datapath.sv -----
`default_nettype none

`include "sobel_edge_magnitude_core_macros.svh"

module sem_datapath #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire sem_pkg::sem_cmd_type         cmd,
   output      sem_pkg::sem_sts_type         sts,
   input  wire logic [sem_pkg::PIX_W-1:0]    req_pixel_in,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [sem_pkg::CSR_IX_W-1:0] csr_index,
   input  wire logic [sem_pkg::CSR_D_W-1:0]  csr_data,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [sem_pkg::PIX_W-1:0]    rsp_magnitude,
   output      logic signed [sem_pkg::GRAD_W-1:0] rsp_grad_x,
   output      logic signed [sem_pkg::GRAD_W-1:0] rsp_grad_y,
   output      logic                         rsp_frame_last
);

   import sem_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int EW = (WW > CFG_W_W) ? WW : CFG_W_W;
   localparam int RW = CFG_H_W;

   // configuration
   logic [CFG_W_W-1:0] width_ff;
   logic [CFG_H_W-1:0] height_ff;
   logic [EW-1:0]      width_ext;
   logic [EW-1:0]      eff_width;
   logic [RW-1:0]      eff_height;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= IMAGE_WIDTH_RST;
         height_ff <= IMAGE_HEIGHT_RST;
      end else if (csr_valid) begin
         if (csr_index == REG_IMAGE_WIDTH) begin
            width_ff <= csr_data[CFG_W_W-1:0];
         end
         if (csr_index == REG_IMAGE_HEIGHT) begin
            height_ff <= csr_data[CFG_H_W-1:0];
         end
      end
   end

   always_comb begin
      width_ext = EW'(width_ff);
      if (width_ext < EW'(3)) begin
         eff_width = EW'(3);
      end else if (width_ext > EW'(MAX_WIDTH)) begin
         eff_width = EW'(MAX_WIDTH);
      end else begin
         eff_width = width_ext;
      end
      eff_height = (height_ff < RW'(3)) ? RW'(3) : height_ff;
   end

   // position counters
   logic [CW-1:0] col_ff;
   logic [RW-1:0] row_ff;
   logic [EW-1:0] col_plus;
   logic [RW:0]   row_plus;
   logic          col_wrap;
   logic          row_wrap;

   assign col_plus = EW'(col_ff) + EW'(1);
   assign row_plus = (RW + 1)'(row_ff) + (RW + 1)'(1);
   assign col_wrap = col_plus >= eff_width;
   assign row_wrap = row_plus >= {1'b0, eff_height};

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (cmd.shift) begin
         if (col_wrap) begin
            col_ff <= '0;
            row_ff <= row_wrap ? '0 : row_plus[RW-1:0];
         end else begin
            col_ff <= col_plus[CW-1:0];
         end
      end
   end

   assign sts.produce = (row_ff >= RW'(2)) && (col_ff >= CW'(2));

   // line stores
   logic [PIX_W-1:0] pix_ff;
   logic [PIX_W-1:0] up_rd;
   logic [PIX_W-1:0] lo_rd;

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff <= req_pixel_in;
      end
   end

   sem_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_upper (
      .clock   (clock),
      .wr_en   (cmd.shift),
      .wr_addr (col_ff),
      .wr_data (lo_rd),
      .rd_addr (col_ff),
      .rd_data (up_rd)
   );

   sem_ram #(
      .WIDTH (PIX_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_lower (
      .clock   (clock),
      .wr_en   (cmd.shift),
      .wr_addr (col_ff),
      .wr_data (pix_ff),
      .rd_addr (col_ff),
      .rd_data (lo_rd)
   );

   // 3x3 window, index row*3+col, col 2 newest
   logic [PIX_W-1:0] win_ff [9];
   logic             last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 9; i++) begin
            win_ff[i] <= '0;
         end
      end else if (cmd.shift) begin
         for (int r = 0; r < 3; r++) begin
            win_ff[r*3]     <= win_ff[r*3 + 1];
            win_ff[r*3 + 1] <= win_ff[r*3 + 2];
         end
         win_ff[2] <= up_rd;
         win_ff[5] <= lo_rd;
         win_ff[8] <= pix_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.shift) begin
         last_ff <= row_wrap && col_wrap;
      end
   end

   // gradients
   logic [9:0]               gx_pos;
   logic [9:0]               gx_neg;
   logic [9:0]               gy_pos;
   logic [9:0]               gy_neg;
   logic signed [GRAD_W-1:0] gx_in;
   logic signed [GRAD_W-1:0] gy_in;
   logic signed [GRAD_W-1:0] gx_ff;
   logic signed [GRAD_W-1:0] gy_ff;

   assign gx_pos = 10'(win_ff[2]) + {1'b0, win_ff[5], 1'b0} + 10'(win_ff[8]);
   assign gx_neg = 10'(win_ff[0]) + {1'b0, win_ff[3], 1'b0} + 10'(win_ff[6]);
   assign gy_pos = 10'(win_ff[6]) + {1'b0, win_ff[7], 1'b0} + 10'(win_ff[8]);
   assign gy_neg = 10'(win_ff[0]) + {1'b0, win_ff[1], 1'b0} + 10'(win_ff[2]);
   assign gx_in  = signed'({1'b0, gx_pos}) - signed'({1'b0, gx_neg});
   assign gy_in  = signed'({1'b0, gy_pos}) - signed'({1'b0, gy_neg});

   always_ff @(posedge clock) begin
      if (cmd.grad) begin
         gx_ff <= gx_in;
         gy_ff <= gy_in;
      end
   end

   // squares, one multiply per cycle
   logic [9:0]  ax;
   logic [9:0]  ay;
   logic [9:0]  sq_op;
   logic [19:0] sq_prod;
   logic [19:0] sqx_ff;
   logic [20:0] sq_in;
   logic [20:0] sq_ff;

   assign ax      = gx_ff[GRAD_W-1] ? 10'(-gx_ff) : gx_ff[9:0];
   assign ay      = gy_ff[GRAD_W-1] ? 10'(-gy_ff) : gy_ff[9:0];
   assign sq_op   = cmd.sq_x ? ax : ay;
   assign sq_prod = 20'(sq_op) * 20'(sq_op);
   assign sq_in   = 21'(sqx_ff) + 21'(sq_prod);

   always_ff @(posedge clock) begin
      if (cmd.sq_x) begin
         sqx_ff <= sq_prod;
      end
      if (cmd.sq_y) begin
         sq_ff <= sq_in;
      end
   end

   // square root, one result bit per cycle
   logic [15:0] rem_ff;
   logic [15:0] root_ff;
   logic        big_ff;
   logic [2:0]  step_ff;
   logic [15:0] root_bit;
   logic [16:0] trial;

   assign root_bit      = 16'h4000 >> {step_ff, 1'b0};
   assign trial         = 17'(root_ff) + 17'(root_bit);
   assign sts.root_done = step_ff == 3'(ROOT_STEPS - 1);

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= '0;
      end else if (cmd.sq_y) begin
         step_ff <= '0;
      end else if (cmd.root) begin
         step_ff <= step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.sq_y) begin
         rem_ff  <= sq_in[15:0];
         root_ff <= '0;
         big_ff  <= |sq_in[20:16];
      end else if (cmd.root) begin
         if (17'(rem_ff) >= trial) begin
            rem_ff  <= rem_ff - trial[15:0];
            root_ff <= (root_ff >> 1) + root_bit;
         end else begin
            root_ff <= root_ff >> 1;
         end
      end
   end

   // output register
   logic                     rsp_valid_ff;
   logic [PIX_W-1:0]         rsp_mag_ff;
   logic [PIX_W-1:0]         rsp_mag_in;
   logic signed [GRAD_W-1:0] rsp_gx_ff;
   logic signed [GRAD_W-1:0] rsp_gy_ff;
   logic                     rsp_last_ff;

   assign rsp_mag_in   = big_ff ? '1 : root_ff[PIX_W-1:0];
   assign sts.out_free = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_mag_ff  <= rsp_mag_in;
         rsp_gx_ff   <= gx_ff;
         rsp_gy_ff   <= gy_ff;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_magnitude  = rsp_mag_ff;
   assign rsp_grad_x     = rsp_gx_ff;
   assign rsp_grad_y     = rsp_gy_ff;
   assign rsp_frame_last = rsp_last_ff;

   `SEM_ASSERT_IMPLIES(a_root_low, cmd.load && !big_ff,
      (21'(rsp_mag_in) * 21'(rsp_mag_in)) <= sq_ff, "root too large")
   `SEM_ASSERT_IMPLIES(a_root_high, cmd.load && !big_ff,
      ((21'(rsp_mag_in) + 21'd1) * (21'(rsp_mag_in) + 21'd1)) > sq_ff, "root too small")
   `SEM_ASSERT_NEXT(a_col_step, cmd.shift,
      (col_ff == '0) || (col_ff == ($past(col_ff) + CW'(1))), "column skipped")
   `SEM_ASSERT_NEXT(a_gx_range, cmd.grad,
      (gx_ff >= -11'sd1020) && (gx_ff <= 11'sd1020), "gradient out of range")

endmodule

`default_nettype wire

// ----- hw/rtl/sobel_edge_magnitude_core.sv -----
// Sobel 3x3 edge detector for 8-bit grayscale pixels in raster order. Each accepted
// pixel updates two line stores and the window; once row and column are both at least 2
// a word carries gx, gy and floor(sqrt(gx^2+gy^2)) saturated to 255 for the pixel one
// row up and one column left, and frame_last marks the final interior pixel. Border
// pixels only shift; pixels that give a result also pass the gradient, gx^2 then gy^2
// on a single multiplier, the one-bit-per-cycle square root and the load. The result
// sits in an output register, so the next pixel is taken while it waits. Image width
// and height are for the user to write on the csr port between frames; the block does
// not enforce it. Widths are clamped to 3..MAX_WIDTH, heights raised to at least 3.
`default_nettype none

module sobel_edge_magnitude_core #(
   parameter int MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output      logic                         req_stall,
   input  wire logic [sem_pkg::PIX_W-1:0]    req_pixel_in,
   output      logic                         rsp_valid,
   input  wire logic                         rsp_stall,
   output      logic [sem_pkg::PIX_W-1:0]    rsp_magnitude,
   output      logic signed [sem_pkg::GRAD_W-1:0] rsp_grad_x,
   output      logic signed [sem_pkg::GRAD_W-1:0] rsp_grad_y,
   output      logic                         rsp_frame_last,
   input  wire logic                         csr_valid,
   output      logic                         csr_ready,
   input  wire logic [sem_pkg::CSR_IX_W-1:0] csr_index,
   input  wire logic [sem_pkg::CSR_D_W-1:0]  csr_data
);

   import sem_pkg::*;

   sem_cmd_type cmd;
   sem_sts_type sts;

   sem_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   sem_datapath #(
      .MAX_WIDTH (MAX_WIDTH)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_pixel_in   (req_pixel_in),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_magnitude  (rsp_magnitude),
      .rsp_grad_x     (rsp_grad_x),
      .rsp_grad_y     (rsp_grad_y),
      .rsp_frame_last (rsp_frame_last)
   );

endmodule

`default_nettype wire
